>>> sv/nsfc_pkg.sv
// Shared types, codes and classification functions for the NMEA sentence framer.
package nsfc_pkg;

    localparam int MaxFrameBytesDefault = 128;
    localparam int QueueDepth           = 2;

    localparam logic [7:0] ChDollar = 8'h24;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChUpperF = 8'h46;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_GOOD,
        ST_BADSUM,
        ST_SHORT,
        ST_OVERFLOW
    } t_status;

    typedef enum logic [1:0] {
        TK_UNKNOWN,
        TK_GP,
        TK_BD,
        TK_GN
    } t_talker;

    typedef enum logic [2:0] {
        KD_OTHER,
        KD_RMC,
        KD_GGA,
        KD_GLL,
        KD_GSA,
        KD_GSV
    } t_kind;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [7:0] data;
        logic       is_dollar;
        logic       is_lf;
        t_hex       hex;
    } t_byte_class;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_frame;
        logic [7:0] position;
        t_status    status;
        t_talker    talker;
        t_kind      kind;
    } t_result;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c inside {[ChZero:ChNine]}) begin
            h.ok  = 1'b1;
            h.val = 4'(c - ChZero);
        end else if (c inside {[ChUpperA:ChUpperF]}) begin
            h.ok  = 1'b1;
            h.val = 4'(c - ChUpperA + 8'd10);
        end
        return h;
    endfunction

    function automatic t_talker classify_talker(input logic [7:0] a, input logic [7:0] b);
        t_talker t;
        t = TK_UNKNOWN;
        if (a == "G" && b == "P") t = TK_GP;
        else if (a == "B" && b == "D") t = TK_BD;
        else if (a == "G" && b == "N") t = TK_GN;
        return t;
    endfunction

    function automatic t_kind classify_kind(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
        t_kind k;
        k = KD_OTHER;
        if (a == "R" && b == "M" && c == "C") k = KD_RMC;
        else if (a == "G" && b == "G" && c == "A") k = KD_GGA;
        else if (a == "G" && b == "L" && c == "L") k = KD_GLL;
        else if (a == "G" && b == "S" && c == "A") k = KD_GSA;
        else if (a == "G" && b == "S" && c == "V") k = KD_GSV;
        return k;
    endfunction

endpackage

>>> sv/nsfc_front.sv
// Input side: accepts received bytes and tags delimiters and hex digits.
module nsfc_front (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // rx_byte[7:0]
    input  logic                i_queue_full,
    output logic                o_push,
    output nsfc_pkg::t_byte_class o_push_data
);
    import nsfc_pkg::*;

    assign s_axis_tready = !i_queue_full;
    assign o_push        = s_axis_tvalid && !i_queue_full;

    always_comb begin
        o_push_data.data      = s_axis_tdata;
        o_push_data.is_dollar = (s_axis_tdata == ChDollar);
        o_push_data.is_lf     = (s_axis_tdata == ChLf);
        o_push_data.hex       = hex_decode(s_axis_tdata);
    end

endmodule

>>> sv/nsfc_queue.sv
// Short queue of classified bytes between the front and back parts.
module nsfc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  nsfc_pkg::t_byte_class i_push_data,
    output logic                  o_full,
    output logic                  o_valid,
    output nsfc_pkg::t_byte_class o_data,
    input  logic                  i_pop
);
    import nsfc_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_byte_class r_slot [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CntW'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        else if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wr_ptr] <= i_push_data;
    end

endmodule

>>> sv/nsfc_back.sv
// Sentence tracker: position, running XOR, recent bytes, classification and result register.
module nsfc_back #(
    parameter int MAX_FRAME_BYTES = nsfc_pkg::MaxFrameBytesDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  nsfc_pkg::t_byte_class i_item,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output nsfc_pkg::t_result     o_result
);
    import nsfc_pkg::*;

    localparam logic [7:0] MaxIndex = 8'(MAX_FRAME_BYTES);

    logic       r_open, n_open;
    logic [7:0] r_index, n_index;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_recent [4];
    logic [7:0] n_recent [4];
    t_hex       r_recent_hex [3];
    t_hex       n_recent_hex [3];
    t_talker    r_talker, n_talker;
    t_kind      r_kind, n_kind;
    logic [7:0] r_type [2];
    logic [7:0] n_type [2];
    logic       r_out_valid;
    t_result    r_result, n_result;

    logic       start, open_now, term, sum_match;
    logic [7:0] e_index, e_xor, sum;
    logic [7:0] e_recent [4];
    t_hex       e_recent_hex [3];
    t_talker    e_talker;
    t_kind      e_kind;
    logic [7:0] e_type [2];
    t_status    status;

    assign o_pop       = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        start    = i_item.is_dollar && !r_open;
        open_now = r_open || i_item.is_dollar;

        // a fresh sentence works from cleared state
        e_index  = start ? 8'd0 : r_index;
        e_xor    = start ? 8'd0 : r_xor;
        e_talker = start ? TK_UNKNOWN : r_talker;
        e_kind   = start ? KD_OTHER : r_kind;
        for (int i = 0; i < 4; i++) e_recent[i] = start ? 8'd0 : r_recent[i];
        for (int i = 0; i < 3; i++) e_recent_hex[i] = start ? t_hex'('0) : r_recent_hex[i];
        for (int i = 0; i < 2; i++) e_type[i] = start ? 8'd0 : r_type[i];

        term = (e_index > 8'd1) && i_item.is_lf && (e_recent[0] == ChCr);
        // strip '*', both checksum characters and CR
        sum  = e_xor ^ e_recent[0] ^ e_recent[1] ^ e_recent[2] ^ e_recent[3];
        sum_match = e_recent_hex[2].ok && e_recent_hex[1].ok
                    && (e_recent_hex[2].val == sum[7:4])
                    && (e_recent_hex[1].val == sum[3:0]);

        n_open   = r_open;
        n_index  = r_index;
        n_xor    = r_xor;
        n_talker = r_talker;
        n_kind   = r_kind;
        n_recent = r_recent;
        n_recent_hex = r_recent_hex;
        n_type   = r_type;
        status   = ST_NONE;

        if (o_pop && open_now) begin
            n_open   = 1'b1;
            n_index  = e_index;
            n_xor    = e_xor;
            n_talker = e_talker;
            n_kind   = e_kind;
            n_recent = e_recent;
            n_recent_hex = e_recent_hex;
            n_type   = e_type;
            if (term) begin
                if (e_index < 8'd5) status = ST_SHORT;
                else status = sum_match ? ST_GOOD : ST_BADSUM;
                n_open  = 1'b0;
                n_index = 8'd0;
            end else begin
                if (e_index == 8'd2) n_talker = classify_talker(e_recent[0], i_item.data);
                if (e_index == 8'd3) n_type[0] = i_item.data;
                if (e_index == 8'd4) n_type[1] = i_item.data;
                if (e_index == 8'd5) n_kind = classify_kind(e_type[0], e_type[1], i_item.data);
                if (e_index >= 8'd1) n_xor = e_xor ^ i_item.data;
                n_recent[3] = e_recent[2];
                n_recent[2] = e_recent[1];
                n_recent[1] = e_recent[0];
                n_recent[0] = i_item.data;
                n_recent_hex[2] = e_recent_hex[1];
                n_recent_hex[1] = e_recent_hex[0];
                n_recent_hex[0] = i_item.hex;
                if (e_index >= MaxIndex) begin
                    status  = ST_OVERFLOW;
                    n_open  = 1'b0;
                    n_index = 8'd0;
                end else begin
                    n_index = e_index + 8'd1;
                end
            end
        end

        n_result.data_byte = i_item.data;
        n_result.in_frame  = open_now;
        n_result.position  = open_now ? e_index : 8'd0;
        n_result.status    = status;
        n_result.talker    = open_now ? n_talker : TK_UNKNOWN;
        n_result.kind      = open_now ? n_kind : KD_OTHER;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_index     <= 8'd0;
            r_xor       <= 8'd0;
            r_talker    <= TK_UNKNOWN;
            r_kind      <= KD_OTHER;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) r_recent[i] <= 8'd0;
            for (int i = 0; i < 3; i++) r_recent_hex[i] <= '0;
            for (int i = 0; i < 2; i++) r_type[i] <= 8'd0;
        end else begin
            r_open       <= n_open;
            r_index      <= n_index;
            r_xor        <= n_xor;
            r_talker     <= n_talker;
            r_kind       <= n_kind;
            r_recent     <= n_recent;
            r_recent_hex <= n_recent_hex;
            r_type       <= n_type;
            if (o_pop) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (o_pop) r_result <= n_result;
    end

endmodule

>>> sv/nmea_sentence_framer_checksum_top.sv
// Top level of the NMEA 0183 sentence framer with XOR checksum check.
//
// Input stream s_axis carries one received character per item. Output stream
// m_axis carries exactly one result item per input item, in order: the byte
// itself, its position in the open sentence, the close status (good, bad
// checksum, too short, overflow) and the talker and sentence type codes.
// A '$' opens a sentence when none is open; CR LF or an overflow closes it.
//
// A byte accepted on s_axis is written into the queue, then registered in the
// result register before it shows as a valid result on m_axis.
// Throughput: one item per cycle when m_axis_tready is high, set by the back
// part's update of the position, running XOR and recent-byte shift register.
//
// A two-entry queue sits between the input side and the tracker, and the
// result register holds while m_axis_tready is low; s_axis_tready drops only
// when the queue is full. Reset empties the queue, clears the result valid and
// returns the tracker to no open sentence with all state zero.
module nmea_sentence_framer_checksum_top #(
    parameter int MAX_FRAME_BYTES = nsfc_pkg::MaxFrameBytesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // data_byte[7:0], position[15:8], frame_status[18:16]
    output logic [5:0]  m_axis_tuser    // in_frame[0], talker[2:1], sentence_kind[5:3]
);
    import nsfc_pkg::*;

    logic        push, queue_full, queue_valid, pop;
    t_byte_class push_data, queue_data;
    t_result     result;

    nsfc_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    nsfc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .o_valid     (queue_valid),
        .o_data      (queue_data),
        .i_pop       (pop)
    );

    nsfc_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_item      (queue_data),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {5'd0, result.status, result.position, result.data_byte};
    assign m_axis_tuser = {result.kind, result.talker, result.in_frame};

endmodule

>>> sv/nsfc_checker.sv
// Port-level checks on the framer output stream, bound to the top level.
module nsfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [5:0]  m_axis_tuser
);
    import nsfc_pkg::*;

    logic [2:0] status;
    assign status = m_axis_tdata[18:16];

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // bytes outside a sentence carry no position, status or codes
    a_outside_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[23:8] == 16'd0 && m_axis_tuser[5:1] == 5'd0)
        else $error("out-of-frame item has frame fields set");

    // a checksum verdict only comes on a line feed at position five or later
    a_verdict_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (status == ST_GOOD || status == ST_BADSUM) |->
            m_axis_tuser[0] && m_axis_tdata[7:0] == ChLf && m_axis_tdata[15:8] >= 8'd5)
        else $error("checksum verdict on wrong byte");

    // a short frame closes on a line feed below position five
    a_short_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_SHORT |->
            m_axis_tdata[7:0] == ChLf && m_axis_tdata[15:8] < 8'd5
            && m_axis_tdata[15:8] > 8'd1)
        else $error("short status on wrong byte");

    // reset drops any pending result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind nmea_sentence_framer_checksum_top nsfc_checker u_nsfc_checker (.*);

>>> tb/nmea_sentence_framer_checksum_top_tb.sv
// Self-checking testbench for the NMEA sentence framer: directed table, length-limit sentences, then random sentences.
`timescale 1ns / 100ps

module nmea_sentence_framer_checksum_top_tb;
    import nsfc_pkg::*;

    localparam int FrameLimit = MaxFrameBytesDefault;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        t_result    res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte[7:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // data_byte[7:0], position[15:8], frame_status[18:16]
    logic [5:0]  m_axis_tuser;           // in_frame[0], talker[2:1], sentence_kind[5:3]

    // Sentence tracker state
    logic       sen_open = 1'b0;
    logic [7:0] sen_index = 8'd0;
    logic [7:0] sen_xor = 8'd0;
    logic [7:0] sen_recent [4] = '{default: 8'h00};
    logic [7:0] sen_type [2] = '{default: 8'h00};
    t_talker    sen_talker = TK_UNKNOWN;
    t_kind      sen_kind = KD_OTHER;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      bytes_accepted = 0;
    bit      steady = 1'b0;

    t_row dir_rows [25] = '{
        '{8'h00, 1'b1, '{8'h00, 1'b0, 8'd0, ST_NONE, TK_UNKNOWN, KD_OTHER}},
        '{8'hFF, 1'b1, '{8'hFF, 1'b0, 8'd0, ST_NONE, TK_UNKNOWN, KD_OTHER}},
        '{ChDollar, 1'b1, '{ChDollar, 1'b1, 8'd0, ST_NONE, TK_UNKNOWN, KD_OTHER}},
        '{ChCr, 1'b0, '0},
        '{ChLf, 1'b1, '{ChLf, 1'b1, 8'd2, ST_SHORT, TK_UNKNOWN, KD_OTHER}},
        '{ChDollar, 1'b0, '0},
        '{"G", 1'b0, '0},
        '{"P", 1'b0, '0},
        '{"G", 1'b0, '0},
        '{"G", 1'b0, '0},
        '{"A", 1'b0, '0},
        '{"*", 1'b0, '0},
        '{"5", 1'b0, '0},
        '{"6", 1'b0, '0},
        '{ChCr, 1'b0, '0},
        '{ChLf, 1'b0, '0},
        '{ChDollar, 1'b0, '0},
        '{"B", 1'b0, '0},
        '{"D", 1'b0, '0},
        '{ChDollar, 1'b0, '0},
        '{"f", 1'b0, '0},
        '{"f", 1'b0, '0},
        '{ChCr, 1'b0, '0},
        '{ChLf, 1'b1, '{ChLf, 1'b1, 8'd7, ST_BADSUM, TK_BD, KD_OTHER}},
        '{8'h7F, 1'b1, '{8'h7F, 1'b0, 8'd0, ST_NONE, TK_UNKNOWN, KD_OTHER}}
    };

    nmea_sentence_framer_checksum_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("nmea_sentence_framer_checksum_top_tb NOT OK");
        $finish;
    end

    // Nibble value of an upper-case hex digit; 16 marks anything else.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= ChZero && c <= ChNine) return {1'b0, 4'(c - ChZero)};
        if (c >= ChUpperA && c <= ChUpperF) return {1'b0, 4'(c - ChUpperA + 8'd10)};
        return 5'd16;
    endfunction

    function automatic t_talker talker_of(input logic [7:0] a, input logic [7:0] b);
        case ({a, b})
            "GP":    return TK_GP;
            "BD":    return TK_BD;
            "GN":    return TK_GN;
            default: return TK_UNKNOWN;
        endcase
    endfunction

    function automatic t_kind kind_of(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
        case ({a, b, c})
            "RMC":   return KD_RMC;
            "GGA":   return KD_GGA;
            "GLL":   return KD_GLL;
            "GSA":   return KD_GSA;
            "GSV":   return KD_GSV;
            default: return KD_OTHER;
        endcase
    endfunction

    // Advance the sentence tracker by one byte and return the result it causes.
    function automatic t_result track_sentence(input logic [7:0] b);
        t_result    r;
        logic [7:0] pos;
        logic [7:0] sum;
        r = '0;
        r.data_byte = b;
        if (b == ChDollar && !sen_open) begin
            sen_open   = 1'b1;
            sen_index  = 8'd0;
            sen_xor    = 8'd0;
            sen_recent = '{default: 8'h00};
            sen_type   = '{default: 8'h00};
            sen_talker = TK_UNKNOWN;
            sen_kind   = KD_OTHER;
        end
        if (!sen_open) return r;
        pos = sen_index;
        if (pos > 8'd1 && b == ChLf && sen_recent[0] == ChCr) begin
            if (pos < 8'd5) begin
                r.status = ST_SHORT;
            end else begin
                // drop '*', both checksum characters and CR from the running sum
                sum = sen_xor ^ sen_recent[0] ^ sen_recent[1] ^ sen_recent[2] ^ sen_recent[3];
                r.status = (nibble_of(sen_recent[2]) == {1'b0, sum[7:4]} &&
                            nibble_of(sen_recent[1]) == {1'b0, sum[3:0]}) ? ST_GOOD : ST_BADSUM;
            end
            sen_open  = 1'b0;
            sen_index = 8'd0;
        end else begin
            if (pos == 8'd2) sen_talker = talker_of(sen_recent[0], b);
            if (pos == 8'd3) sen_type[0] = b;
            if (pos == 8'd4) sen_type[1] = b;
            if (pos == 8'd5) sen_kind = kind_of(sen_type[0], sen_type[1], b);
            if (pos >= 8'd1) sen_xor = sen_xor ^ b;
            sen_recent[3] = sen_recent[2];
            sen_recent[2] = sen_recent[1];
            sen_recent[1] = sen_recent[0];
            sen_recent[0] = b;
            if (pos >= FrameLimit) begin
                r.status  = ST_OVERFLOW;
                sen_open  = 1'b0;
                sen_index = 8'd0;
            end else begin
                sen_index = pos + 8'd1;
            end
        end
        r.in_frame = 1'b1;
        r.position = pos;
        r.talker   = sen_talker;
        r.kind     = sen_kind;
        return r;
    endfunction

    function automatic logic [7:0] rand_text();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? ChZero + 8'(n) : ChUpperA + 8'(n - 4'd10);
    endfunction

    // Offer one byte, idling at random first unless steady is set; queue its expected result once accepted.
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_result typed_res);
        t_result r;
        while (!steady && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = track_sentence(b);
        pending_results.push_back(typed ? typed_res : r);
        bytes_accepted++;
    endtask

    // Build one sentence, mostly well formed, sometimes broken, and send it.
    task automatic send_sentence();
        logic [7:0] line [$];
        logic [7:0] sum;
        int         shape;
        int         body_len;
        shape = $urandom_range(99);
        line.push_back(ChDollar);
        if (shape >= 94) begin
            repeat ($urandom_range(0, 2)) line.push_back(rand_text());
            line.push_back(ChCr);
            line.push_back(ChLf);
        end else begin
            case ($urandom_range(3))
                0:       begin line.push_back("G"); line.push_back("P"); end
                1:       begin line.push_back("B"); line.push_back("D"); end
                2:       begin line.push_back("G"); line.push_back("N"); end
                default: begin line.push_back(rand_text()); line.push_back(rand_text()); end
            endcase
            case ($urandom_range(5))
                0: begin line.push_back("R"); line.push_back("M"); line.push_back("C"); end
                1: begin line.push_back("G"); line.push_back("G"); line.push_back("A"); end
                2: begin line.push_back("G"); line.push_back("L"); line.push_back("L"); end
                3: begin line.push_back("G"); line.push_back("S"); line.push_back("A"); end
                4: begin line.push_back("G"); line.push_back("S"); line.push_back("V"); end
                default: repeat (3) line.push_back(rand_text());
            endcase
            body_len = ($urandom_range(19) == 0) ? $urandom_range(100, 135) : $urandom_range(0, 20);
            repeat (body_len) line.push_back(rand_text());
            sum = 8'h00;
            for (int i = 1; i < line.size(); i++) sum = sum ^ line[i];
            line.push_back("*");
            if (shape >= 70 && shape < 80) begin
                sum = sum ^ (8'h01 << $urandom_range(7));
            end
            if (shape >= 80 && shape < 88) begin
                // lower-case or random high digit, mostly a mismatch
                line.push_back($urandom_range(1) ? 8'($urandom_range(8'h61, 8'h66)) : rand_text());
            end else begin
                line.push_back(hex_char(sum[7:4]));
            end
            line.push_back(hex_char(sum[3:0]));
            // leave the sentence open without its terminator now and then
            if (shape < 88) begin
                line.push_back(ChCr);
                line.push_back(ChLf);
            end
        end
        foreach (line[i]) send_byte(line[i], 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 36);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data_byte = m_axis_tdata[7:0];
            got.position  = m_axis_tdata[15:8];
            got.status    = t_status'(m_axis_tdata[18:16]);
            got.in_frame  = m_axis_tuser[0];
            got.talker    = t_talker'(m_axis_tuser[2:1]);
            got.kind      = t_kind'(m_axis_tuser[5:3]);
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: result with nothing expected: data=%h pos=%0d st=%0d",
                             $realtime, got.data_byte, got.position, got.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.data_byte !== want.data_byte || got.in_frame !== want.in_frame ||
                    got.position !== want.position || got.status !== want.status ||
                    got.talker !== want.talker || got.kind !== want.kind) begin
                    if (mismatch_count < 10)
                        $display({"%0t: mismatch exp data=%h in=%b pos=%0d st=%0d tk=%0d kd=%0d",
                                  " got data=%h in=%b pos=%0d st=%0d tk=%0d kd=%0d"}, $realtime,
                                 want.data_byte, want.in_frame, want.position, want.status,
                                 want.talker, want.kind, got.data_byte, got.in_frame,
                                 got.position, got.status, got.talker, got.kind);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int random_base;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);

        // hold off until every queued result has drained
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        // run past the length limit, then close a sentence right at the limit
        send_byte(ChDollar, 1'b0, '0);
        repeat (FrameLimit) send_byte(rand_text(), 1'b0, '0);
        send_byte(ChDollar, 1'b0, '0);
        repeat (FrameLimit - 2) send_byte(rand_text(), 1'b0, '0);
        send_byte(ChCr, 1'b0, '0);
        send_byte(ChLf, 1'b0, '0);

        random_base = bytes_accepted;
        while (bytes_accepted - random_base < 130) begin
            steady = (bytes_accepted - random_base >= 40 && bytes_accepted - random_base < 100);
            if ($urandom_range(99) < 30) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            send_sentence();
        end
        steady = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("nmea_sentence_framer_checksum_top_tb OK");
        end else begin
            $display("nmea_sentence_framer_checksum_top_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/nsfc_pkg.sv
sv/nsfc_front.sv
sv/nsfc_queue.sv
sv/nsfc_back.sv
sv/nmea_sentence_framer_checksum_top.sv
sv/nsfc_checker.sv
tb/nmea_sentence_framer_checksum_top_tb.sv
